// ----- hw/rtl/mmbc_pkg.sv -----
// Shared types, constants and bit-packing helpers for the modmul block cipher.
package mmbc_pkg;

    localparam int unsigned NUM_WORDS  = 4;
    localparam int unsigned DIV_STAGES = 8;
    localparam int unsigned DIV_BITS   = 4;

    localparam logic [7:0] CHK_SEED = 8'hF8;
    localparam logic [7:0] LEN_MASK = 8'h3D;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE,
        REG_READY,
        REG_MOD_LO,
        REG_MOD_HI,
        REG_MUL_LO,
        REG_MUL_HI,
        REG_XOR_LO,
        REG_XOR_HI
    } cfg_reg_t;

    // Per-beat working set carried down the pipeline
    typedef struct packed {
        logic [3:0][31:0] w;      // encrypt: reduced words, decrypt: unchained words
        logic [3:0][15:0] pt;     // encrypt: plaintext words, decrypt: recovered words
        logic [15:0]      carry;  // chaining value for the next word
        logic [7:0]       chk;    // encrypt: check byte, decrypt: received check byte
        logic [7:0]       lenx;   // encrypt: length, decrypt: received length byte
    } item_t;

    // Stream bit p sits at bit 7-(p mod 8) of byte p/8; the map is its own inverse.
    function automatic logic [87:0] swap_bit_order(input logic [87:0] s);
        logic [87:0] d;
        d = '0;
        for (int p = 0; p < 88; p++) begin
            d[(p & ~7) + 7 - (p & 7)] = s[p];
        end
        return d;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7 - k];
        end
        return r;
    endfunction

    // 18-bit word in stream order: bits 7..0, 15..8, 17, 16
    function automatic logic [17:0] word_to_seq(input logic [17:0] w);
        logic [17:0] q;
        q = '0;
        for (int k = 0; k < 8; k++) begin
            q[k]     = w[7 - k];
            q[8 + k] = w[15 - k];
        end
        q[16] = w[17];
        q[17] = w[16];
        return q;
    endfunction

    function automatic logic [17:0] seq_to_word(input logic [17:0] q);
        logic [17:0] w;
        w = '0;
        for (int k = 0; k < 8; k++) begin
            w[7 - k]  = q[k];
            w[15 - k] = q[8 + k];
        end
        w[17] = q[16];
        w[16] = q[17];
        return w;
    endfunction

    function automatic logic [7:0] xor_bytes(input logic [63:0] v);
        logic [7:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            r = r ^ v[8 * k +: 8];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/mmbc_modmul.sv -----
// Pipelined (a * mul) mod 2^32, then mod modulus: operand stage, one multiply stage,
// eight divide stages.
module mmbc_modmul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  mmbc_pkg::item_t     in_item,
    input  logic [31:0]         in_opd,
    input  logic [31:0]         mul_key,
    input  logic [31:0]         mod_key,
    output logic                out_valid,
    output mmbc_pkg::item_t     out_item,
    output logic [31:0]         out_rem
);

    // Four restoring remainder steps
    function automatic logic [31:0] rem_step(input logic [31:0] r,
                                             input logic [3:0] xb,
                                             input logic [31:0] m);
        logic [32:0] t;
        logic [31:0] acc;
        acc = r;
        for (int k = 3; k >= 0; k--) begin
            t = {acc, xb[k]};
            if (t >= {1'b0, m}) begin
                t = t - {1'b0, m};
            end
            acc = t[31:0];
        end
        return acc;
    endfunction

    // Operand stage
    logic                 op_v_reg;
    mmbc_pkg::item_t      op_item_reg;
    logic [31:0]          op_reg;

    // Product stage
    logic                 pr_v_reg;
    mmbc_pkg::item_t      pr_item_reg;
    logic [31:0]          pr_reg;

    // Divide stages
    logic                 dv_v_reg    [mmbc_pkg::DIV_STAGES];
    mmbc_pkg::item_t      dv_item_reg [mmbc_pkg::DIV_STAGES];
    logic [31:0]          dv_x_reg    [mmbc_pkg::DIV_STAGES];
    logic [31:0]          dv_rem_reg  [mmbc_pkg::DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_v_reg <= 1'b0;
            pr_v_reg <= 1'b0;
        end
        else if (en)
        begin
            op_v_reg <= in_valid;
            pr_v_reg <= op_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_item_reg <= in_item;
            op_reg      <= in_opd;
            pr_item_reg <= op_item_reg;
            pr_reg      <= op_reg * mul_key;
        end
    end

    for (genvar j = 0; j < mmbc_pkg::DIV_STAGES; j++) begin : g_div
        logic                 v_prev;
        mmbc_pkg::item_t      item_prev;
        logic [31:0]          x_prev;
        logic [31:0]          rem_prev;

        if (j == 0) begin : g_first
            assign v_prev    = pr_v_reg;
            assign item_prev = pr_item_reg;
            assign x_prev    = pr_reg;
            assign rem_prev  = '0;
        end
        else begin : g_rest
            assign v_prev    = dv_v_reg[j - 1];
            assign item_prev = dv_item_reg[j - 1];
            assign x_prev    = dv_x_reg[j - 1];
            assign rem_prev  = dv_rem_reg[j - 1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[j] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_item_reg[j] <= item_prev;
                dv_x_reg[j]    <= x_prev;
                dv_rem_reg[j]  <= rem_step(rem_prev,
                    x_prev[31 - mmbc_pkg::DIV_BITS * j -: mmbc_pkg::DIV_BITS], mod_key);
            end
        end
    end

    // Zero modulus passes the product through
    assign out_valid = dv_v_reg[mmbc_pkg::DIV_STAGES - 1];
    assign out_item  = dv_item_reg[mmbc_pkg::DIV_STAGES - 1];
    assign out_rem   = (mod_key == '0) ? dv_x_reg[mmbc_pkg::DIV_STAGES - 1]
                                       : dv_rem_reg[mmbc_pkg::DIV_STAGES - 1];

endmodule

// ----- hw/rtl/modmul_block_cipher_8to11_unit.sv -----
// Top level: modmul block cipher, 8 plaintext bytes to 11 ciphertext bytes and back.
// Pipeline: input stage, four word units of 10 stages each, output register.
// Throughput: one beat per cycle; all stages advance together when the output
// register is empty or taken, so a stall holds every stage in place.
// Reset: asynchronous active low; clears valid bits and all configuration registers.
module modmul_block_cipher_8to11_unit (
    input  logic          clk,
    input  logic          rst_n,
    // configuration write port
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_wdata,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,  // block_low[63:0], block_high[87:64], valid_len[91:88]
    // output stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata   // out_low[63:0], out_high[87:64],
                                         // recovered_len[95:88], check_ok[96]
);

    // Configuration registers
    logic             mode_reg;
    logic             ready_reg;
    logic [3:0][31:0] kmod_reg;
    logic [3:0][31:0] kmul_reg;
    logic [3:0][31:0] kxor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            ready_reg <= 1'b0;
            kmod_reg  <= '0;
            kmul_reg  <= '0;
            kxor_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (mmbc_pkg::cfg_reg_t'(cfg_index))
                mmbc_pkg::REG_MODE:   mode_reg       <= cfg_wdata[0];
                mmbc_pkg::REG_READY:  ready_reg      <= cfg_wdata[0];
                mmbc_pkg::REG_MOD_LO: kmod_reg[1:0]  <= cfg_wdata;
                mmbc_pkg::REG_MOD_HI: kmod_reg[3:2]  <= cfg_wdata;
                mmbc_pkg::REG_MUL_LO: kmul_reg[1:0]  <= cfg_wdata;
                mmbc_pkg::REG_MUL_HI: kmul_reg[3:2]  <= cfg_wdata;
                mmbc_pkg::REG_XOR_LO: kxor_reg[1:0]  <= cfg_wdata;
                mmbc_pkg::REG_XOR_HI: kxor_reg[3:2]  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline advance
    logic en;
    logic m_valid_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Input unpacking
    logic [63:0] block_low;
    logic [23:0] block_high;
    logic [3:0]  valid_len;

    assign block_low  = s_axis_tdata[63:0];
    assign block_high = s_axis_tdata[87:64];
    assign valid_len  = s_axis_tdata[91:88];

    // Input stage preprocessing
    mmbc_pkg::item_t pre_item;
    logic [87:0]     dec_seq;

    always_comb
    begin
        pre_item = '0;
        dec_seq  = mmbc_pkg::swap_bit_order({block_high, block_low});
        if (!mode_reg)
        begin
            for (int i = 0; i < 4; i++) begin
                pre_item.pt[i] = block_low[16 * i +: 16];
            end
            pre_item.chk  = mmbc_pkg::CHK_SEED ^ mmbc_pkg::xor_bytes(block_low);
            pre_item.lenx = {4'b0, valid_len};
        end
        else
        begin
            for (int i = 0; i < 4; i++) begin
                pre_item.w[i] = {14'b0, mmbc_pkg::seq_to_word(dec_seq[18 * i +: 18])};
            end
            // undo the forward chain, last word first
            for (int i = 3; i > 0; i--) begin
                pre_item.w[i - 1] = pre_item.w[i - 1] ^ kxor_reg[i - 1]
                                  ^ {16'b0, pre_item.w[i][15:0]};
            end
            pre_item.lenx = mmbc_pkg::rev8(dec_seq[72 +: 8]);
            pre_item.chk  = mmbc_pkg::rev8(dec_seq[80 +: 8]);
        end
    end

    // Input stage register
    logic            in_v_reg;
    mmbc_pkg::item_t in_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (en)
        begin
            in_v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_item_reg <= pre_item;
        end
    end

    // Word chain: one modmul unit per word
    logic            ch_v    [5];
    mmbc_pkg::item_t ch_item [5];

    assign ch_v[0]    = in_v_reg;
    assign ch_item[0] = in_item_reg;

    for (genvar i = 0; i < mmbc_pkg::NUM_WORDS; i++) begin : g_word
        logic [31:0]     opd;
        logic            u_v;
        mmbc_pkg::item_t u_item;
        logic [31:0]     u_rem;

        assign opd = mode_reg ? ch_item[i].w[i]
                              : (kxor_reg[i] ^ {16'b0, ch_item[i].pt[i]}
                                 ^ {16'b0, ch_item[i].carry});

        mmbc_modmul u_modmul (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (ch_v[i]),
            .in_item   (ch_item[i]),
            .in_opd    (opd),
            .mul_key   (kmul_reg[i]),
            .mod_key   (kmod_reg[i]),
            .out_valid (u_v),
            .out_item  (u_item),
            .out_rem   (u_rem)
        );

        // Fold the remainder back into the item
        always_comb
        begin
            ch_item[i + 1] = u_item;
            if (!mode_reg)
            begin
                ch_item[i + 1].w[i]  = u_rem;
                ch_item[i + 1].carry = u_rem[15:0];
            end
            else
            begin
                ch_item[i + 1].pt[i] = u_rem[15:0] ^ kxor_reg[i][15:0] ^ u_item.carry;
                ch_item[i + 1].carry = u_item.w[i][15:0];
            end
        end

        assign ch_v[i + 1] = u_v;
    end

    // Output formatting
    mmbc_pkg::item_t fin;
    logic [3:0][31:0] enc_w;
    logic [87:0]      enc_seq;
    logic [87:0]      enc_bytes;
    logic [7:0]       plain_chk;
    logic [63:0]      out_low_next;
    logic [23:0]      out_high_next;
    logic [7:0]       rlen_next;
    logic             ok_next;

    assign fin = ch_item[4];

    always_comb
    begin
        enc_w    = fin.w;
        for (int i = 0; i < 3; i++) begin
            enc_w[i] = fin.w[i] ^ kxor_reg[i] ^ {16'b0, fin.w[i + 1][15:0]};
        end
        enc_seq = '0;
        for (int i = 0; i < 4; i++) begin
            enc_seq[18 * i +: 18] = mmbc_pkg::word_to_seq(enc_w[i][17:0]);
        end
        enc_seq[72 +: 8] = mmbc_pkg::rev8(fin.chk ^ fin.lenx ^ mmbc_pkg::LEN_MASK);
        enc_seq[80 +: 8] = mmbc_pkg::rev8(fin.chk);
        enc_bytes = mmbc_pkg::swap_bit_order(enc_seq);
        plain_chk = mmbc_pkg::CHK_SEED ^ mmbc_pkg::xor_bytes(fin.pt);

        out_low_next  = '0;
        out_high_next = '0;
        rlen_next     = '0;
        ok_next       = 1'b0;
        if (ready_reg)
        begin
            if (!mode_reg)
            begin
                out_low_next  = enc_bytes[63:0];
                out_high_next = enc_bytes[87:64];
                ok_next       = 1'b1;
            end
            else
            begin
                out_low_next = fin.pt;
                rlen_next    = fin.chk ^ fin.lenx ^ mmbc_pkg::LEN_MASK;
                ok_next      = (plain_chk == fin.chk);
            end
        end
    end

    // Output register
    logic [96:0] m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= ch_v[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= {ok_next, rlen_next, out_high_next, out_low_next};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, m_data_reg};

endmodule
